/* rtl/core/pba_pkg.sv */
`timescale 1ns / 1ps

package pba_pkg;

    localparam int LOW_PORT  = 1024;
    localparam int HIGH_PORT = 65535;

    // ports covered by the map, zero when the range is empty
    localparam int SPAN    = (HIGH_PORT >= LOW_PORT) ? (HIGH_PORT - LOW_PORT + 1) : 0;
    localparam int MAP_W   = 64;
    localparam int BIT_AW  = $clog2(MAP_W);
    localparam int WORDS   = (SPAN == 0) ? 1 : ((SPAN + MAP_W - 1) / MAP_W);
    localparam int WORD_AW = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int STEP_W  = $clog2(WORDS + 1);
    localparam int TAIL    = SPAN % MAP_W;

    localparam logic [15:0] LOW_P16  = 16'(LOW_PORT);
    localparam logic [15:0] HIGH_P16 = 16'(HIGH_PORT);

    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'((SPAN == 0) ? 0 : ((SPAN - 1) / MAP_W));
    localparam logic [STEP_W-1:0]  LAST_STEP = STEP_W'(WORDS);
    localparam logic [MAP_W-1:0]   LAST_MASK = (SPAN == 0) ? '0 :
                                               (TAIL == 0) ? '1 :
                                               ({MAP_W{1'b1}} >> (MAP_W - TAIL));

    localparam logic [1:0] KIND_CLAIM   = 2'd0;
    localparam logic [1:0] KIND_ALLOC   = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] port_number;
    } req_t;

    typedef struct packed {
        logic        ok;
        logic [15:0] granted_port;
    } rsp_t;

    typedef struct packed {
        logic              found;
        logic [BIT_AW-1:0] index;
    } first_set_t;

    function automatic logic in_range(input logic [15:0] p);
        return (p >= LOW_P16) && (p <= HIGH_P16);
    endfunction

    // bits of a map word that stand for real ports
    function automatic logic [MAP_W-1:0] word_mask(input logic [WORD_AW-1:0] a);
        logic [MAP_W-1:0] m;
        if (a == LAST_WORD)
            m = LAST_MASK;
        else if (a > LAST_WORD)
            m = '0;
        else
            m = '1;
        return m;
    endfunction

endpackage

/* rtl/core/pba_ram.sv */
`timescale 1ns / 1ps

module pba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/pba_first_set.sv */
`timescale 1ns / 1ps

module pba_first_set
    import pba_pkg::*;
(
    input  logic [MAP_W-1:0] bits,
    output first_set_t       res
);

    logic [MAP_W-1:0]  lowest;
    logic [BIT_AW-1:0] index;

    // isolate the lowest set bit, then encode its position
    assign lowest = bits & (~bits + MAP_W'(1));

    always_comb
    begin
        index = '0;
        for (int j = 0; j < MAP_W; j++)
        begin
            if (lowest[j])
                index = index | BIT_AW'(j);
        end
    end

    assign res.found = |bits;
    assign res.index = index;

endmodule

/* rtl/core/port_bitmap_allocator.sv */
`timescale 1ns / 1ps

// Round-robin port allocator over a free bitmap held in a single RAM of
// 64-bit words (one bit per port, LOW_PORT..HIGH_PORT). After reset the block
// runs a clearing pass that sets every map word, with req_stall high. Claim
// and release read their map word, then write it back modified (a claim only
// when the port is free, a release only when it is in range); unused kinds
// only read it and return a failure. Allocate reads one map word per cycle
// starting at the round-robin pointer until it finds a free port or has read
// the start word a second time. One request is
// in flight at a time; a new request may be accepted while the previous
// result still waits on rsp_stall.
module port_bitmap_allocator
    import pba_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EVAL  = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [WORD_AW-1:0]  clr_reg, clr_next;
    logic [1:0]          op_reg, op_next;
    logic [15:0]         port_reg, port_next;
    logic [BIT_AW-1:0]   bit_reg, bit_next;
    logic [WORD_AW-1:0]  addr_reg, addr_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [15:0]         cand_reg, cand_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg, rsp_next;

    logic                wr_en;
    logic [WORD_AW-1:0]  wr_addr;
    logic [MAP_W-1:0]    wr_data;
    logic                rd_en;
    logic [WORD_AW-1:0]  rd_addr;
    logic [MAP_W-1:0]    rd_data;

    logic [15:0]         ptr;
    logic [15:0]         ptr_slot;
    logic [15:0]         req_slot;
    logic [MAP_W-1:0]    bit_onehot;
    logic [MAP_W-1:0]    upper_mask;
    logic [MAP_W-1:0]    step_mask;
    logic [MAP_W-1:0]    cand_bits;
    first_set_t          fs;
    logic [MAP_W-1:0]    fs_onehot;
    logic [15:0]         grant;
    logic                out_free;
    logic                accept;
    logic                hit;

    pba_ram #(
        .WIDTH (MAP_W),
        .DEPTH (WORDS)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pba_first_set u_first (
        .bits (cand_bits),
        .res  (fs)
    );

    assign ptr       = in_range(cand_reg) ? cand_reg : LOW_P16;
    assign ptr_slot  = ptr - LOW_P16;
    assign req_slot  = req.port_number - LOW_P16;

    assign bit_onehot = MAP_W'(1) << bit_reg;
    assign upper_mask = {MAP_W{1'b1}} << bit_reg;

    always_comb
    begin
        if (step_reg == '0)
            step_mask = upper_mask;
        else if (step_reg == LAST_STEP)
            step_mask = ~upper_mask;    // second visit of the start word
        else
            step_mask = '1;
    end

    assign cand_bits = rd_data & word_mask(addr_reg) & step_mask;
    assign fs_onehot = MAP_W'(1) << fs.index;
    assign grant     = LOW_P16 + 16'({addr_reg, fs.index});

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign hit       = in_range(port_reg) && rd_data[bit_reg];

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        op_next        = op_reg;
        port_next      = port_reg;
        bit_next       = bit_reg;
        addr_next      = addr_reg;
        step_next      = step_reg;
        cand_next      = cand_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        wr_addr        = addr_reg;
        wr_data        = rd_data;
        rd_en          = 1'b0;
        rd_addr        = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = '1;
                clr_next = clr_reg + WORD_AW'(1);
                if (clr_reg == WORD_AW'(WORDS - 1))
                    state_next = ST_IDLE;
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    rd_en     = 1'b1;
                    op_next   = req.kind;
                    port_next = req.port_number;
                    step_next = '0;
                    if (req.kind == KIND_ALLOC)
                    begin
                        rd_addr  = WORD_AW'(ptr_slot >> BIT_AW);
                        bit_next = ptr_slot[BIT_AW-1:0];
                    end
                    else
                    begin
                        rd_addr  = in_range(req.port_number) ?
                                   WORD_AW'(req_slot >> BIT_AW) : '0;
                        bit_next = req_slot[BIT_AW-1:0];
                    end
                    addr_next  = rd_addr;
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL:
            begin
                unique case (op_reg)
                    KIND_CLAIM:
                    begin
                        if (out_free)
                        begin
                            wr_en          = hit;
                            wr_data        = rd_data & ~bit_onehot;
                            rsp_valid_next = 1'b1;
                            rsp_next.ok    = hit;
                            rsp_next.granted_port = hit ? port_reg : 16'd0;
                            state_next     = ST_IDLE;
                        end
                    end

                    KIND_RELEASE:
                    begin
                        if (out_free)
                        begin
                            wr_en          = in_range(port_reg);
                            wr_data        = rd_data | bit_onehot;
                            rsp_valid_next = 1'b1;
                            rsp_next.ok    = in_range(port_reg);
                            rsp_next.granted_port = 16'd0;
                            state_next     = ST_IDLE;
                        end
                    end

                    KIND_ALLOC:
                    begin
                        if (fs.found)
                        begin
                            if (out_free)
                            begin
                                wr_en          = 1'b1;
                                wr_data        = rd_data & ~fs_onehot;
                                rsp_valid_next = 1'b1;
                                rsp_next.ok    = 1'b1;
                                rsp_next.granted_port = grant;
                                cand_next      = (grant >= HIGH_P16) ? LOW_P16 :
                                                 (grant + 16'd1);
                                state_next     = ST_IDLE;
                            end
                        end
                        else if (step_reg == LAST_STEP)
                        begin
                            if (out_free)
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_next.ok    = 1'b0;
                                rsp_next.granted_port = 16'd0;
                                state_next     = ST_IDLE;
                            end
                        end
                        else
                        begin
                            rd_en     = 1'b1;
                            rd_addr   = (addr_reg == LAST_WORD) ? '0 :
                                        (addr_reg + WORD_AW'(1));
                            addr_next = rd_addr;
                            step_next = step_reg + STEP_W'(1);
                        end
                    end

                    default:
                    begin
                        if (out_free)
                        begin
                            rsp_valid_next = 1'b1;
                            rsp_next.ok    = 1'b0;
                            rsp_next.granted_port = 16'd0;
                            state_next     = ST_IDLE;
                        end
                    end
                endcase
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            cand_reg      <= LOW_P16;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cand_reg      <= cand_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        port_reg <= port_next;
        bit_reg  <= bit_next;
        addr_reg <= addr_next;
        step_reg <= step_next;
        rsp_reg  <= rsp_next;
    end

endmodule

/* rtl/core/pba_checker.sv */
`timescale 1ns / 1ps

module pba_checker
    import pba_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // one request in flight: an accepted word closes the input side
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted while previous one still in flight");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response word changed");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.ok || (rsp.granted_port == 16'd0))
        else $error("failed response carries a port");

    a_grant_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.granted_port != 16'd0) |->
            (rsp.granted_port >= LOW_P16) && (rsp.granted_port <= HIGH_P16))
        else $error("granted port outside the managed range");

endmodule

bind port_bitmap_allocator pba_checker u_pba_checker (.*);
